@@ design/itpoc_pkg.sv @@
// ----------------------------------------------------------------------------
// itpoc_pkg
// Shared widths, phase codes and divider handshake types for the two-pass
// zero-offset calibration block.
// ----------------------------------------------------------------------------
package itpoc_pkg;

	localparam int SAMPLE_WIDTH_DEF  = 16;
	localparam int FRACTION_BITS_DEF = 4;
	localparam int AXES_DEF          = 3;

	localparam int SUM_WIDTH       = 32;
	localparam int OFS_WIDTH       = 22;
	localparam int COUNT_WIDTH     = 16;
	localparam int NUM_CH          = 6;
	localparam int AXES_PER_SENSOR = 3;
	localparam int CH_WIDTH        = 3;
	localparam int PHASE_WIDTH     = 2;

	localparam logic [PHASE_WIDTH-1:0] PHASE_FIRST  = 2'd0;
	localparam logic [PHASE_WIDTH-1:0] PHASE_SECOND = 2'd1;
	localparam logic [PHASE_WIDTH-1:0] PHASE_DONE   = 2'd2;

	typedef struct packed {
		logic                   start;
		logic [SUM_WIDTH-1:0]   dividend;
		logic [COUNT_WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                        busy;
		logic                        done;
		logic signed [OFS_WIDTH-1:0] mean;
	} div_rsp_t;

endpackage

@@ design/itpoc_if.sv @@
// ----------------------------------------------------------------------------
// itpoc_if
// Valid/ready channels: six-axis sample input and offset result output.
// ----------------------------------------------------------------------------
interface itpoc_sample_if #(
	parameter int SAMPLE_WIDTH = itpoc_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] gyro_x;
	logic signed [SAMPLE_WIDTH-1:0] gyro_y;
	logic signed [SAMPLE_WIDTH-1:0] gyro_z;
	logic signed [SAMPLE_WIDTH-1:0] accel_x;
	logic signed [SAMPLE_WIDTH-1:0] accel_y;
	logic signed [SAMPLE_WIDTH-1:0] accel_z;

	modport source (
		output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
		input  ready
	);
	modport sink (
		input  valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
		output ready
	);
endinterface

interface itpoc_offset_if;
	logic                                          valid;
	logic                                          ready;
	logic signed [itpoc_pkg::OFS_WIDTH-1:0]        gyro_offset_x;
	logic signed [itpoc_pkg::OFS_WIDTH-1:0]        gyro_offset_y;
	logic signed [itpoc_pkg::OFS_WIDTH-1:0]        gyro_offset_z;
	logic signed [itpoc_pkg::OFS_WIDTH-1:0]        accel_offset_x;
	logic signed [itpoc_pkg::OFS_WIDTH-1:0]        accel_offset_y;
	logic signed [itpoc_pkg::OFS_WIDTH-1:0]        accel_offset_z;
	logic        [itpoc_pkg::PHASE_WIDTH-1:0]      phase;
	logic                                          pass_done;

	modport source (
		output valid, gyro_offset_x, gyro_offset_y, gyro_offset_z,
		       accel_offset_x, accel_offset_y, accel_offset_z, phase, pass_done,
		input  ready
	);
	modport sink (
		input  valid, gyro_offset_x, gyro_offset_y, gyro_offset_z,
		       accel_offset_x, accel_offset_y, accel_offset_z, phase, pass_done,
		output ready
	);
endinterface

@@ design/itpoc_divider.sv @@
// ----------------------------------------------------------------------------
// itpoc_divider
// Bit-serial restoring divider: (sum * 2^FRACTION_BITS) / count, truncated
// toward zero and saturated to the offset width. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module itpoc_divider #(
	parameter int FRACTION_BITS = itpoc_pkg::FRACTION_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  itpoc_pkg::div_req_t req,
	output itpoc_pkg::div_rsp_t rsp
);
	localparam int N   = itpoc_pkg::SUM_WIDTH + FRACTION_BITS;
	localparam int CW  = itpoc_pkg::COUNT_WIDTH;
	localparam int OW  = itpoc_pkg::OFS_WIDTH;
	localparam int NCW = $clog2(N);
	localparam logic [N-1:0]   POS_LIM = N'(2**(OW-1) - 1);
	localparam logic [N-1:0]   NEG_LIM = N'(2**(OW-1));
	localparam logic [NCW-1:0] LAST    = NCW'(N - 1);

	logic                 busy_q;
	logic                 fin_q;
	logic                 done_q;
	logic [NCW-1:0]       cnt_q;
	logic [N-1:0]         dq_q;
	logic [CW-1:0]        rem_q;
	logic [CW-1:0]        div_q;
	logic                 neg_q;
	logic signed [OW-1:0] mean_q;

	logic [itpoc_pkg::SUM_WIDTH-1:0] mag;
	logic [CW:0]                     rem_shift;
	logic                            ge;
	logic [CW:0]                     rem_next;
	logic signed [OW-1:0]            mean_sat;

	assign mag       = req.dividend[itpoc_pkg::SUM_WIDTH-1]
	                 ? itpoc_pkg::SUM_WIDTH'(0) - req.dividend : req.dividend;
	assign rem_shift = {rem_q, dq_q[N-1]};
	assign ge        = rem_shift >= {1'b0, div_q};
	assign rem_next  = ge ? rem_shift - {1'b0, div_q} : rem_shift;

	always_comb begin
		if (!neg_q) begin
			mean_sat = (dq_q > POS_LIM) ? OW'(POS_LIM) : OW'(dq_q);
		end else begin
			mean_sat = (dq_q > NEG_LIM) ? OW'(NEG_LIM) : OW'(N'(0) - dq_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start && !busy_q && !fin_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + NCW'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q && !fin_q) begin
			dq_q  <= N'(mag) << FRACTION_BITS;
			rem_q <= '0;
			div_q <= req.divisor;
			neg_q <= req.dividend[itpoc_pkg::SUM_WIDTH-1];
		end else if (busy_q) begin
			dq_q  <= {dq_q[N-2:0], ge};
			rem_q <= rem_next[CW-1:0];
		end
		if (fin_q) begin
			mean_q <= mean_sat;
		end
	end

	assign rsp.busy = busy_q | fin_q;
	assign rsp.done = done_q;
	assign rsp.mean = mean_q;

endmodule

@@ design/imu_two_pass_offset_calibration_core.sv @@
// ----------------------------------------------------------------------------
// imu_two_pass_offset_calibration_core
// Two-pass zero-offset calibration: accumulate six channels per pass, take
// the mean of each through one shared serial divider, set then refine offsets.
// ----------------------------------------------------------------------------
// Path: an accepted sample is registered; while calibrating, each active channel
// is added into its sum in turn before the result is registered; when finished
// or disabled it goes straight to the result. A sample that ends a pass also
// starts the shared divider for each channel in turn, one quotient bit per cycle.
// Throughput: one sample at a time; the next is taken once the result is
// registered. Reset: offsets zero, phase finished until a count is written.
module imu_two_pass_offset_calibration_core #(
	parameter int SAMPLE_WIDTH  = itpoc_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRACTION_BITS = itpoc_pkg::FRACTION_BITS_DEF,
	parameter int AXES          = itpoc_pkg::AXES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	itpoc_sample_if.sink                        samples,
	itpoc_offset_if.source                      offsets,
	input  logic                                cfg_we,
	input  logic [itpoc_pkg::COUNT_WIDTH-1:0]   cfg_wdata
);
	localparam int NCH = itpoc_pkg::NUM_CH;
	localparam int SW  = itpoc_pkg::SUM_WIDTH;
	localparam int OW  = itpoc_pkg::OFS_WIDTH;
	localparam int CW  = itpoc_pkg::COUNT_WIDTH;
	localparam int CHW = itpoc_pkg::CH_WIDTH;
	localparam int PW  = itpoc_pkg::PHASE_WIDTH;
	localparam logic [CHW-1:0] LAST_CH = CHW'(NCH - 1);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_ACC       = 3'd1;
	localparam logic [2:0] ST_DIV_START = 3'd2;
	localparam logic [2:0] ST_DIV_WAIT  = 3'd3;
	localparam logic [2:0] ST_RESULT    = 3'd4;

	function automatic logic active_ch(input logic [CHW-1:0] ch);
		logic [CHW-1:0] axis;
		axis = (ch < CHW'(itpoc_pkg::AXES_PER_SENSOR))
		     ? ch : ch - CHW'(itpoc_pkg::AXES_PER_SENSOR);
		return int'(axis) < AXES;
	endfunction

	logic [2:0]           state_q;
	logic [CHW-1:0]       ch_q;
	logic [CW-1:0]        counter_q;
	logic [CW-1:0]        count_q;
	logic [PW-1:0]        phase_q;
	logic [SW-1:0]        sums_q [NCH];
	logic signed [OW-1:0] offs_q [NCH];
	logic                 done_flag_q;
	logic                 out_valid_q;

	logic signed [SAMPLE_WIDTH-1:0] samp_q [NCH];
	logic signed [OW-1:0]           out_ofs_q [NCH];
	logic [PW-1:0]                  out_phase_q;
	logic                           out_done_q;

	logic signed [SAMPLE_WIDTH-1:0] in_vec [NCH];
	logic                           calibrating;
	logic [CW-1:0]                  counter_inc;
	logic                           can_load;
	logic signed [OW:0]             ofs_sum;
	logic signed [OW-1:0]           new_ofs;
	logic [PW-1:0]                  phase_out;

	itpoc_pkg::div_req_t div_req;
	itpoc_pkg::div_rsp_t div_rsp;

	assign in_vec[0] = samples.gyro_x;
	assign in_vec[1] = samples.gyro_y;
	assign in_vec[2] = samples.gyro_z;
	assign in_vec[3] = samples.accel_x;
	assign in_vec[4] = samples.accel_y;
	assign in_vec[5] = samples.accel_z;

	assign calibrating = (phase_q == itpoc_pkg::PHASE_FIRST
	                   || phase_q == itpoc_pkg::PHASE_SECOND) && (count_q != '0);
	assign counter_inc = counter_q + CW'(1);
	assign can_load    = !out_valid_q || offsets.ready;
	assign phase_out   = (phase_q == itpoc_pkg::PHASE_FIRST
	                   || phase_q == itpoc_pkg::PHASE_SECOND)
	                   ? phase_q : itpoc_pkg::PHASE_DONE;

	assign ofs_sum = {offs_q[ch_q][OW-1], offs_q[ch_q]} + {div_rsp.mean[OW-1], div_rsp.mean};

	always_comb begin
		if (phase_q == itpoc_pkg::PHASE_FIRST) begin
			new_ofs = div_rsp.mean;
		end else if (ofs_sum[OW] != ofs_sum[OW-1]) begin
			new_ofs = ofs_sum[OW] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
		end else begin
			new_ofs = ofs_sum[OW-1:0];
		end
	end

	assign div_req.start    = (state_q == ST_DIV_START);
	assign div_req.dividend = sums_q[ch_q];
	assign div_req.divisor  = count_q;

	itpoc_divider #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			counter_q   <= '0;
			count_q     <= '0;
			phase_q     <= itpoc_pkg::PHASE_DONE;
			done_flag_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NCH; i++) begin
				sums_q[i] <= '0;
				offs_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_RESULT && can_load) begin
				out_valid_q <= 1'b1;
			end else if (offsets.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						done_flag_q <= 1'b0;
						ch_q        <= '0;
						state_q     <= calibrating ? ST_ACC : ST_RESULT;
					end
				end
				ST_ACC: begin
					if (active_ch(ch_q)) begin
						sums_q[ch_q] <= sums_q[ch_q] + SW'(samp_q[ch_q]);
					end
					if (ch_q == LAST_CH) begin
						ch_q      <= '0;
						counter_q <= counter_inc;
						state_q   <= (counter_inc >= count_q) ? ST_DIV_START : ST_RESULT;
					end else begin
						ch_q <= ch_q + CHW'(1);
					end
				end
				ST_DIV_START: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (active_ch(ch_q)) begin
							offs_q[ch_q] <= new_ofs;
						end
						if (ch_q == LAST_CH) begin
							for (int i = 0; i < NCH; i++) begin
								sums_q[i] <= '0;
							end
							ch_q        <= '0;
							counter_q   <= '0;
							phase_q     <= (phase_q == itpoc_pkg::PHASE_FIRST)
							             ? itpoc_pkg::PHASE_SECOND : itpoc_pkg::PHASE_DONE;
							done_flag_q <= 1'b1;
							state_q     <= ST_RESULT;
						end else begin
							ch_q    <= ch_q + CHW'(1);
							state_q <= ST_DIV_START;
						end
					end
				end
				ST_RESULT: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// count write: restart calibration (first pass, or done for a zero count)
			if (cfg_we) begin
				count_q   <= cfg_wdata;
				counter_q <= '0;
				phase_q   <= (cfg_wdata != '0) ? itpoc_pkg::PHASE_FIRST : itpoc_pkg::PHASE_DONE;
				for (int i = 0; i < NCH; i++) begin
					sums_q[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && samples.valid) begin
			for (int i = 0; i < NCH; i++) begin
				samp_q[i] <= in_vec[i];
			end
		end
		if (state_q == ST_RESULT && can_load) begin
			for (int i = 0; i < NCH; i++) begin
				out_ofs_q[i] <= offs_q[i];
			end
			out_phase_q <= phase_out;
			out_done_q  <= done_flag_q;
		end
	end

	assign samples.ready          = (state_q == ST_IDLE);
	assign offsets.valid          = out_valid_q;
	assign offsets.gyro_offset_x  = out_ofs_q[0];
	assign offsets.gyro_offset_y  = out_ofs_q[1];
	assign offsets.gyro_offset_z  = out_ofs_q[2];
	assign offsets.accel_offset_x = out_ofs_q[3];
	assign offsets.accel_offset_y = out_ofs_q[4];
	assign offsets.accel_offset_z = out_ofs_q[5];
	assign offsets.phase          = out_phase_q;
	assign offsets.pass_done      = out_done_q;

`ifndef ASSERT_OFF
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_done_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		(offsets.valid && offsets.pass_done) |-> (offsets.phase != itpoc_pkg::PHASE_FIRST))
		else $error("pass completion reported in first phase");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_wdata != '0) |=> (phase_q == itpoc_pkg::PHASE_FIRST && counter_q == '0))
		else $error("count write did not restart calibration");

	a_counter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && calibrating) |-> (counter_q < count_q))
		else $error("sample counter reached count without ending the pass");
`endif

endmodule
